@@ rtl/lsrs_pkg.sv @@
package lsrs_pkg;

    localparam int NUM_CH          = 5;
    localparam int CH_W            = 3;
    localparam int SAMPLE_W        = 12;
    localparam int LEVEL_W         = 16;
    localparam int LED_W           = 5;
    localparam int PHASE_W         = 3;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam logic [LEVEL_W-1:0] LIMIT_RESET = 16'd30000;
    localparam logic [PHASE_W-1:0] LAST_PHASE  = 3'd4;

    typedef enum logic {
        OP_CONV = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        opcode_t                     opcode;
        sample_t [NUM_CH-1:0]        samples;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } item_beat_t;

    // bit k set: channel k takes the lit sample in this phase
    function automatic logic [NUM_CH-1:0] lit_map(input logic [PHASE_W-1:0] p);
        logic [NUM_CH-1:0] m;
        unique case (p)
            3'd1:    m = 5'h04;
            3'd2:    m = 5'h11;
            3'd3:    m = 5'h02;
            3'd4:    m = 5'h08;
            default: m = 5'h00;
        endcase
        return m;
    endfunction

    function automatic logic [LED_W-1:0] next_drive(input logic [PHASE_W-1:0] p);
        logic [LED_W-1:0] d;
        unique case (p)
            3'd1:    d = 5'h11;
            3'd2:    d = 5'h02;
            3'd3:    d = 5'h08;
            3'd4:    d = 5'h00;
            default: d = 5'h04;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/lsrs_in_stage.sv @@
module lsrs_in_stage (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    item_valid,
    output logic                                    item_stall,
    input  logic                                    opcode,
    input  logic [lsrs_pkg::SAMPLE_W-1:0]           sample_ch0,
    input  logic [lsrs_pkg::SAMPLE_W-1:0]           sample_ch1,
    input  logic [lsrs_pkg::SAMPLE_W-1:0]           sample_ch2,
    input  logic [lsrs_pkg::SAMPLE_W-1:0]           sample_ch3,
    input  logic [lsrs_pkg::SAMPLE_W-1:0]           sample_ch4,
    input  logic                                    consume,
    output lsrs_pkg::item_beat_t                    beat
);

    logic            valid_reg;
    logic            valid_next;
    lsrs_pkg::item_t item_reg;
    lsrs_pkg::item_t item_next;
    logic            load;

    assign item_stall = valid_reg && !consume;
    assign load       = item_valid && !item_stall;

    always_comb
    begin
        item_next = item_reg;
        if (load)
        begin
            item_next.opcode     = lsrs_pkg::opcode_t'(opcode);
            item_next.samples[0] = sample_ch0;
            item_next.samples[1] = sample_ch1;
            item_next.samples[2] = sample_ch2;
            item_next.samples[3] = sample_ch3;
            item_next.samples[4] = sample_ch4;
        end
        priority if (load)
            valid_next = 1'b1;
        else if (consume)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign beat.valid = valid_reg;
    assign beat.item  = item_reg;

endmodule

@@ rtl/lsrs_engine.sv @@
module lsrs_engine #(
    parameter int SAMPLE_BITS = lsrs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lsrs_pkg::item_beat_t                beat,
    output logic                                consume,
    input  logic [lsrs_pkg::LEVEL_W-1:0]        level_limit,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [lsrs_pkg::LED_W-1:0]          led_mask,
    output logic                                start_conversion,
    output logic                                levels_valid,
    output logic [lsrs_pkg::CH_W-1:0]           channel,
    output logic [lsrs_pkg::LEVEL_W-1:0]        level,
    output logic signed [lsrs_pkg::LEVEL_W-1:0] level_change,
    output logic                                last
);

    localparam int StoreW = SAMPLE_BITS;

    logic [lsrs_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [lsrs_pkg::LED_W-1:0]   led_drive_reg, led_drive_next;
    logic [lsrs_pkg::CH_W-1:0]    ch_reg, ch_next;
    logic [StoreW-1:0]            lit_reg  [lsrs_pkg::NUM_CH];
    logic [StoreW-1:0]            lit_next [lsrs_pkg::NUM_CH];
    logic [StoreW-1:0]            dark_reg  [lsrs_pkg::NUM_CH];
    logic [StoreW-1:0]            dark_next [lsrs_pkg::NUM_CH];
    logic [lsrs_pkg::LEVEL_W-1:0] prev_reg  [lsrs_pkg::NUM_CH];
    logic [lsrs_pkg::LEVEL_W-1:0] prev_next [lsrs_pkg::NUM_CH];

    logic                                result_valid_reg, result_valid_next;
    logic [lsrs_pkg::LED_W-1:0]          led_mask_reg, led_mask_next;
    logic                                start_reg, start_next;
    logic                                levels_valid_reg, levels_valid_next;
    logic [lsrs_pkg::CH_W-1:0]           channel_reg, channel_next;
    logic [lsrs_pkg::LEVEL_W-1:0]        level_reg, level_next;
    logic signed [lsrs_pkg::LEVEL_W-1:0] change_reg, change_next;
    logic                                last_reg, last_next;

    logic                                advance;
    logic                                fire;
    logic                                is_tick;
    logic                                last_ch;
    logic [lsrs_pkg::PHASE_W-1:0]        phase_eff;
    logic [lsrs_pkg::NUM_CH-1:0]         lit_sel;
    logic [lsrs_pkg::LEVEL_W-1:0]        cur_level;
    logic [lsrs_pkg::LEVEL_W-1:0]        cur_change;

    assign advance   = !result_valid_reg || !result_stall;
    assign fire      = advance && beat.valid;
    assign is_tick   = beat.item.opcode == lsrs_pkg::OP_TICK;
    assign last_ch   = ch_reg == lsrs_pkg::CH_W'(lsrs_pkg::NUM_CH - 1);
    assign consume   = fire && (!is_tick || last_ch);
    assign phase_eff = (phase_reg <= lsrs_pkg::LAST_PHASE) ? phase_reg : '0;
    assign lit_sel   = lsrs_pkg::lit_map(phase_eff);

    // level wraps modulo 2^16, as does the change
    assign cur_level  = lsrs_pkg::LEVEL_W'(lit_reg[ch_reg])
                      - lsrs_pkg::LEVEL_W'(dark_reg[ch_reg]);
    assign cur_change = prev_reg[ch_reg] - cur_level;

    always_comb
    begin
        phase_next        = phase_reg;
        led_drive_next    = led_drive_reg;
        ch_next           = ch_reg;
        lit_next          = lit_reg;
        dark_next         = dark_reg;
        prev_next         = prev_reg;
        led_mask_next     = led_mask_reg;
        start_next        = start_reg;
        levels_valid_next = levels_valid_reg;
        channel_next      = channel_reg;
        level_next        = level_reg;
        change_next       = change_reg;
        last_next         = last_reg;

        priority if (fire)
            result_valid_next = 1'b1;
        else if (advance)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;

        if (fire)
        begin
            if (is_tick)
            begin
                prev_next[ch_reg] = cur_level;
                ch_next           = last_ch ? '0 : ch_reg + 1'b1;
                led_mask_next     = led_drive_reg;
                start_next        = 1'b1;
                levels_valid_next = 1'b1;
                channel_next      = ch_reg;
                level_next        = (cur_level > level_limit) ? '0 : cur_level;
                change_next       = signed'(cur_change);
                last_next         = last_ch;
            end
            else
            begin
                for (int c = 0; c < lsrs_pkg::NUM_CH; c++)
                begin
                    if (lit_sel[c])
                        lit_next[c] = StoreW'(beat.item.samples[c]);
                    else
                        dark_next[c] = StoreW'(beat.item.samples[c]);
                end
                led_drive_next    = lsrs_pkg::next_drive(phase_eff);
                phase_next        = (phase_eff == lsrs_pkg::LAST_PHASE) ? '0
                                  : phase_eff + 1'b1;
                led_mask_next     = lsrs_pkg::next_drive(phase_eff);
                start_next        = phase_eff != lsrs_pkg::LAST_PHASE;
                levels_valid_next = 1'b0;
                channel_next      = '0;
                level_next        = '0;
                change_next       = '0;
                last_next         = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= '0;
            led_drive_reg    <= '0;
            ch_reg           <= '0;
            result_valid_reg <= 1'b0;
            for (int c = 0; c < lsrs_pkg::NUM_CH; c++)
            begin
                lit_reg[c]  <= '0;
                dark_reg[c] <= '0;
                prev_reg[c] <= '0;
            end
        end
        else
        begin
            phase_reg        <= phase_next;
            led_drive_reg    <= led_drive_next;
            ch_reg           <= ch_next;
            result_valid_reg <= result_valid_next;
            lit_reg          <= lit_next;
            dark_reg         <= dark_next;
            prev_reg         <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        led_mask_reg     <= led_mask_next;
        start_reg        <= start_next;
        levels_valid_reg <= levels_valid_next;
        channel_reg      <= channel_next;
        level_reg        <= level_next;
        change_reg       <= change_next;
        last_reg         <= last_next;
    end

    assign result_valid     = result_valid_reg;
    assign led_mask         = led_mask_reg;
    assign start_conversion = start_reg;
    assign levels_valid     = levels_valid_reg;
    assign channel          = channel_reg;
    assign level            = level_reg;
    assign level_change     = change_reg;
    assign last             = last_reg;

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= lsrs_pkg::LAST_PHASE)
        else $error("phase out of range");

    a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
        ch_reg <= lsrs_pkg::CH_W'(lsrs_pkg::NUM_CH - 1))
        else $error("channel counter out of range");

    a_tick_held: assert property (@(posedge clk) disable iff (!rst_n)
        ch_reg != '0 |-> beat.valid && beat.item.opcode == lsrs_pkg::OP_TICK)
        else $error("tick released before its last channel");

    a_mid_tick: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !last_reg |-> levels_valid_reg && start_reg)
        else $error("non-final beat not a level beat");

    a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && levels_valid_reg && last_reg
        |-> channel_reg == lsrs_pkg::CH_W'(lsrs_pkg::NUM_CH - 1))
        else $error("last level beat not on final channel");
`endif

endmodule

@@ rtl/led_synchronous_reflectance_sampler.sv @@
// an accepted item is held in the input register, its result in the output
// registers; a conversion-done item gives one result, a tick one per channel,
// one result per cycle unless stalled, through the single level/limit datapath
// an input register lets the next item in while a result waits on stall
// reset: rst_n asynchronous active low, clears phase, emitter drive, sample and
// level stores; level_limit resets to 30000
module led_synchronous_reflectance_sampler #(
    parameter int SAMPLE_BITS = lsrs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lsrs_pkg::LEVEL_W-1:0]        cfg_data,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                opcode,
    input  logic [lsrs_pkg::SAMPLE_W-1:0]       sample_ch0,
    input  logic [lsrs_pkg::SAMPLE_W-1:0]       sample_ch1,
    input  logic [lsrs_pkg::SAMPLE_W-1:0]       sample_ch2,
    input  logic [lsrs_pkg::SAMPLE_W-1:0]       sample_ch3,
    input  logic [lsrs_pkg::SAMPLE_W-1:0]       sample_ch4,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [lsrs_pkg::LED_W-1:0]          led_mask,
    output logic                                start_conversion,
    output logic                                levels_valid,
    output logic [lsrs_pkg::CH_W-1:0]           channel,
    output logic [lsrs_pkg::LEVEL_W-1:0]        level,
    output logic signed [lsrs_pkg::LEVEL_W-1:0] level_change,
    output logic                                last
);

    logic [lsrs_pkg::LEVEL_W-1:0] limit_reg;
    logic [lsrs_pkg::LEVEL_W-1:0] limit_next;
    lsrs_pkg::item_beat_t         beat;
    logic                         consume;

    assign cfg_ready  = 1'b1;
    assign limit_next = (cfg_valid && cfg_ready) ? cfg_data : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= lsrs_pkg::LIMIT_RESET;
        else
            limit_reg <= limit_next;
    end

    lsrs_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .opcode     (opcode),
        .sample_ch0 (sample_ch0),
        .sample_ch1 (sample_ch1),
        .sample_ch2 (sample_ch2),
        .sample_ch3 (sample_ch3),
        .sample_ch4 (sample_ch4),
        .consume    (consume),
        .beat       (beat)
    );

    lsrs_engine #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_engine (
        .clk              (clk),
        .rst_n            (rst_n),
        .beat             (beat),
        .consume          (consume),
        .level_limit      (limit_reg),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .led_mask         (led_mask),
        .start_conversion (start_conversion),
        .levels_valid     (levels_valid),
        .channel          (channel),
        .level            (level),
        .level_change     (level_change),
        .last             (last)
    );

endmodule
